FILE: rtl/strm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strm_pkg
// Shared types, codes and helpers for the sparse-table range-minimum core.
// ----------------------------------------------------------------------------
package strm_pkg;

   localparam int MAX_ELEMENTS_DEF = 1024;
   localparam int LEVELS_DEF       = 11;
   localparam int VALUE_WIDTH_DEF  = 32;

   // query index ports are fixed width
   localparam int IDX_W = 10;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BLD_INIT,
      ST_BLD_RD_A,
      ST_BLD_RD_B,
      ST_BLD_WR,
      ST_QRY_RD_A,
      ST_QRY_RD_B,
      ST_QRY_OUT
   } state_type;

   typedef struct packed {
      logic load_we;     // write element to level 0 and bump count if room
      logic qry_latch;   // capture query range and level
      logic bld_start;   // level 1, column 0
      logic rd_en;       // issue table read
      logic rd_second;   // second block of the pair
      logic rd_build;    // build addressing (level - 1)
      logic hold_en;     // keep first read beat
      logic bld_we;      // write merged entry and step
      logic set_closed;  // build finished
   } cmd_type;

   typedef struct packed {
      logic bld_go;      // current level exists for this count
      logic bld_more;    // another column on this level
      logic qry_bad;     // incoming query is rejected
   } status_type;

   // floor(log2(len)) for a nonzero range length
   function automatic logic [4:0] floor_log2(input logic [IDX_W:0] len);
      logic [4:0] r;
      r = '0;
      for (int b = 0; b <= IDX_W; b++) begin
         if (len[b]) begin
            r = 5'(b);
         end
      end
      return r;
   endfunction

endpackage

FILE: rtl/strm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strm_ctrl
// Sequencer for loads, table build and two-read range queries.
// ----------------------------------------------------------------------------
module strm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_kind,
   input  logic                req_last_element,
   input  strm_pkg::status_type status,
   output strm_pkg::cmd_type   cmd,
   output logic                busy,
   output logic                rsp_valid
);

   strm_pkg::state_type state_ff;
   strm_pkg::state_type state_in;
   logic                accept;

   assign accept = start && (state_ff == strm_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= strm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         strm_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_kind == strm_pkg::KIND_QUERY) begin
                  state_in = status.qry_bad ? strm_pkg::ST_QRY_OUT : strm_pkg::ST_QRY_RD_A;
               end else if (req_last_element) begin
                  state_in = strm_pkg::ST_BLD_INIT;
               end
            end
         end
         strm_pkg::ST_BLD_INIT: begin
            state_in = status.bld_go ? strm_pkg::ST_BLD_RD_A : strm_pkg::ST_IDLE;
         end
         strm_pkg::ST_BLD_RD_A: state_in = strm_pkg::ST_BLD_RD_B;
         strm_pkg::ST_BLD_RD_B: state_in = strm_pkg::ST_BLD_WR;
         strm_pkg::ST_BLD_WR: begin
            state_in = status.bld_more ? strm_pkg::ST_BLD_RD_A : strm_pkg::ST_BLD_INIT;
         end
         strm_pkg::ST_QRY_RD_A: state_in = strm_pkg::ST_QRY_RD_B;
         strm_pkg::ST_QRY_RD_B: state_in = strm_pkg::ST_QRY_OUT;
         strm_pkg::ST_QRY_OUT:  state_in = strm_pkg::ST_IDLE;
         default:               state_in = strm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         strm_pkg::ST_IDLE: begin
            busy          = 1'b0;
            cmd.load_we   = accept && (req_kind == strm_pkg::KIND_LOAD);
            cmd.bld_start = accept && (req_kind == strm_pkg::KIND_LOAD) && req_last_element;
            cmd.qry_latch = accept && (req_kind == strm_pkg::KIND_QUERY);
         end
         strm_pkg::ST_BLD_INIT: begin
            cmd.set_closed = !status.bld_go;
         end
         strm_pkg::ST_BLD_RD_A: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_build = 1'b1;
         end
         strm_pkg::ST_BLD_RD_B: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_build  = 1'b1;
            cmd.rd_second = 1'b1;
            cmd.hold_en   = 1'b1;
         end
         strm_pkg::ST_BLD_WR: begin
            cmd.bld_we = 1'b1;
         end
         strm_pkg::ST_QRY_RD_A: begin
            cmd.rd_en = 1'b1;
         end
         strm_pkg::ST_QRY_RD_B: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_second = 1'b1;
            cmd.hold_en   = 1'b1;
         end
         strm_pkg::ST_QRY_OUT: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

FILE: rtl/strm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strm_datapath
// Sparse table memory, element count, level/column counters and min merge.
// ----------------------------------------------------------------------------
module strm_datapath #(
   parameter int MAX_ELEMENTS = strm_pkg::MAX_ELEMENTS_DEF,
   parameter int LEVELS       = strm_pkg::LEVELS_DEF,
   parameter int VALUE_WIDTH  = strm_pkg::VALUE_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  strm_pkg::cmd_type          cmd,
   output strm_pkg::status_type       status,
   input  logic [VALUE_WIDTH-1:0]     req_value,
   input  logic [strm_pkg::IDX_W-1:0] req_left_index,
   input  logic [strm_pkg::IDX_W-1:0] req_right_index,
   output logic [VALUE_WIDTH-1:0]     rsp_range_minimum,
   output logic                       rsp_bad_range
);

   localparam int DEPTH = LEVELS * MAX_ELEMENTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = $clog2(MAX_ELEMENTS);
   localparam int CW    = $clog2(MAX_ELEMENTS + 1);
   localparam int LW    = $clog2(LEVELS + 1);

   logic [VALUE_WIDTH-1:0] mem [DEPTH];

   // control state
   logic [CW-1:0] count_ff, count_in;
   logic          closed_ff, closed_in;
   // payload
   logic [LW-1:0]          lvl_ff;
   logic [PW-1:0]          pos_ff;
   logic [PW-1:0]          right_ff;
   logic                   bad_ff;
   logic [VALUE_WIDTH-1:0] rdata_ff;
   logic [VALUE_WIDTH-1:0] hold_ff;

   logic [CW-1:0]          base;
   logic                   room;
   logic [LW-1:0]          rd_lvl;
   logic [PW-1:0]          rd_pos;
   logic [AW-1:0]          rd_addr;
   logic [AW-1:0]          wr_addr;
   logic                   wr_en;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic [VALUE_WIDTH-1:0] merged;
   logic [PW-1:0]          half;
   logic [PW:0]            blk_q;
   logic [CW-1:0]          blk_b;
   logic [strm_pkg::IDX_W:0] q_len;
   logic [4:0]             q_lg;
   logic [LW-1:0]          q_lvl;

   // a new array restarts once the previous one was built
   assign base = closed_ff ? '0 : count_ff;
   assign room = (32'(base) < 32'(MAX_ELEMENTS));

   assign merged = ($signed(hold_ff) < $signed(rdata_ff)) ? hold_ff : rdata_ff;

   assign q_len = {1'b0, req_right_index} - {1'b0, req_left_index} + 1'b1;
   assign q_lg  = strm_pkg::floor_log2(q_len);
   assign q_lvl = (32'(q_lg) > 32'(LEVELS - 1)) ? LW'(LEVELS - 1) : LW'(q_lg);

   assign status.qry_bad = !closed_ff || (req_left_index > req_right_index)
                           || (32'(req_right_index) >= 32'(count_ff));
   assign status.bld_go  = (32'(lvl_ff) < 32'(LEVELS)) && ((count_ff >> lvl_ff) != '0);
   assign blk_b          = CW'(1) << lvl_ff;
   assign status.bld_more = ((CW + 1)'(pos_ff) + (CW + 1)'(1) + (CW + 1)'(blk_b))
                            <= (CW + 1)'(count_ff);

   // second block: build takes i + 2^(k-1), query ends the block at right
   assign half  = PW'(1) << (lvl_ff - LW'(1));
   assign blk_q = (PW + 1)'(1) << lvl_ff;

   always_comb begin
      rd_lvl = cmd.rd_build ? (lvl_ff - LW'(1)) : lvl_ff;
      if (!cmd.rd_second) begin
         rd_pos = pos_ff;
      end else if (cmd.rd_build) begin
         rd_pos = pos_ff + half;
      end else begin
         rd_pos = PW'({1'b0, right_ff} + (PW + 1)'(1) - blk_q);
      end
   end

   assign rd_addr = AW'(rd_lvl) * AW'(MAX_ELEMENTS) + AW'(rd_pos);

   always_comb begin
      if (cmd.bld_we) begin
         wr_en   = 1'b1;
         wr_addr = AW'(lvl_ff) * AW'(MAX_ELEMENTS) + AW'(pos_ff);
         wr_data = merged;
      end else begin
         wr_en   = cmd.load_we && room;
         wr_addr = AW'(PW'(base));
         wr_data = req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      count_in  = count_ff;
      closed_in = closed_ff;
      if (cmd.load_we) begin
         closed_in = 1'b0;
         count_in  = room ? (base + CW'(1)) : base;
      end
      if (cmd.set_closed) begin
         closed_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         closed_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         closed_ff <= closed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.qry_latch) begin
         pos_ff   <= PW'(req_left_index);
         right_ff <= PW'(req_right_index);
         lvl_ff   <= q_lvl;
         bad_ff   <= status.qry_bad;
      end else if (cmd.bld_start) begin
         lvl_ff <= LW'(1);
         pos_ff <= '0;
      end else if (cmd.bld_we) begin
         if (status.bld_more) begin
            pos_ff <= pos_ff + PW'(1);
         end else begin
            lvl_ff <= lvl_ff + LW'(1);
            pos_ff <= '0;
         end
      end
      if (cmd.hold_en) begin
         hold_ff <= rdata_ff;
      end
   end

   assign rsp_range_minimum = bad_ff ? '0 : merged;
   assign rsp_bad_range     = bad_ff;

endmodule

FILE: rtl/sparse_table_range_min_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_table_range_min_core
// Static range-minimum engine over a sparse table held in one memory.
// ----------------------------------------------------------------------------
// Load: a plain load keeps the core idle, so the next beat may follow next cycle.
// Build after the last load: for every level k < LEVELS with 2^k <= count,
//   each entry takes two reads and one write on one port.
// Query: reads in QRY_RD_A and QRY_RD_B, result strobe in QRY_OUT; a rejected
//   query strobes the cycle after accept; none overlap. Receiver cannot stall.
// Reset clears count and closed flag; table contents are undefined until built.
module sparse_table_range_min_core #(
   parameter int MAX_ELEMENTS = strm_pkg::MAX_ELEMENTS_DEF,
   parameter int LEVELS       = strm_pkg::LEVELS_DEF,
   parameter int VALUE_WIDTH  = strm_pkg::VALUE_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_kind,
   input  logic [VALUE_WIDTH-1:0]     req_value,
   input  logic                       req_last_element,
   input  logic [strm_pkg::IDX_W-1:0] req_left_index,
   input  logic [strm_pkg::IDX_W-1:0] req_right_index,
   output logic                       rsp_valid,
   output logic [VALUE_WIDTH-1:0]     rsp_range_minimum,
   output logic                       rsp_bad_range
);

   strm_pkg::cmd_type    cmd;
   strm_pkg::status_type status;

   strm_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_kind         (req_kind),
      .req_last_element (req_last_element),
      .status           (status),
      .cmd              (cmd),
      .busy             (busy),
      .rsp_valid        (rsp_valid)
   );

   strm_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .LEVELS       (LEVELS),
      .VALUE_WIDTH  (VALUE_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_value         (req_value),
      .req_left_index    (req_left_index),
      .req_right_index   (req_right_index),
      .rsp_range_minimum (rsp_range_minimum),
      .rsp_bad_range     (rsp_bad_range)
   );

   // a result beat follows a busy cycle, or directly a rejected query's accept
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("result beat without a pending query");

   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_range) |-> (rsp_range_minimum == '0))
      else $error("rejected query returned nonzero minimum");

   a_plain_load_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == strm_pkg::KIND_LOAD) && !req_last_element)
      |=> !busy)
      else $error("plain load stalled the input");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == strm_pkg::KIND_QUERY)) |=> (busy && !rsp_valid)
      || (busy && rsp_valid))
      else $error("query accept did not go busy");

endmodule
